>>> rtl/core/tdp_pkg.sv
// Shared types, constants and microcode ROM for the trial-division prime tester.
package tdp_pkg;

    localparam int NUM_WIDTH = 32;
    localparam int CNT_W     = (NUM_WIDTH > 2) ? $clog2(NUM_WIDTH) : 1;
    localparam int STEP_W    = 4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_D_INC,
        OP_EMIT0,
        OP_EMIT1
    } op_t;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_START,
        CND_LT2,
        CND_LT4,
        CND_EVEN,
        CND_DIV_BUSY,
        CND_D_GT_Q
    } cond_t;

    // Remainder-zero test has its own flag bit, ORed with the condition code
    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic              rem_test;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic lt2;
        logic lt4;
        logic even;
        logic div_busy;
        logic d_gt_q;
        logic rem_zero;
    } dp_status_t;

    localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] S_DIV_INIT = 4'd4;
    localparam logic [STEP_W-1:0] S_DIV_STEP = 4'd5;
    localparam logic [STEP_W-1:0] S_EMIT0    = 4'd9;
    localparam logic [STEP_W-1:0] S_EMIT1    = 4'd10;

    // Program: screen small/even values, then loop over odd divisors.
    // Each trial divides n by d once; quotient gives the d*d > n exit.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{op: OP_NOP, cond: CND_ALWAYS, rem_test: 1'b0, target: S_IDLE};
        unique case (step)
            4'd0:  w = '{OP_LOAD,     CND_NO_START, 1'b0, S_IDLE};
            4'd1:  w = '{OP_NOP,      CND_LT2,      1'b0, S_EMIT0};
            4'd2:  w = '{OP_NOP,      CND_LT4,      1'b0, S_EMIT1};
            4'd3:  w = '{OP_NOP,      CND_EVEN,     1'b0, S_EMIT0};
            4'd4:  w = '{OP_DIV_INIT, CND_NEVER,    1'b0, S_IDLE};
            4'd5:  w = '{OP_DIV_STEP, CND_DIV_BUSY, 1'b0, S_DIV_STEP};
            4'd6:  w = '{OP_NOP,      CND_D_GT_Q,   1'b0, S_EMIT1};
            4'd7:  w = '{OP_NOP,      CND_NEVER,    1'b1, S_EMIT0};
            4'd8:  w = '{OP_D_INC,    CND_ALWAYS,   1'b0, S_DIV_INIT};
            4'd9:  w = '{OP_EMIT0,    CND_ALWAYS,   1'b0, S_IDLE};
            4'd10: w = '{OP_EMIT1,    CND_ALWAYS,   1'b0, S_IDLE};
            default: w = '{OP_NOP,    CND_ALWAYS,   1'b0, S_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/tdp_seq.sv
// Microcode sequencer: step counter, ROM fetch and conditional jump.
module tdp_seq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  tdp_pkg::dp_status_t      status,
    output tdp_pkg::op_t             op,
    output logic                     busy
);

    logic [tdp_pkg::STEP_W-1:0] step_reg;
    logic [tdp_pkg::STEP_W-1:0] step_next;
    tdp_pkg::ucode_t            uw;
    logic                       cond_hit;
    logic                       take;

    assign uw = tdp_pkg::ucode_rom(step_reg);

    always_comb
    begin
        unique case (uw.cond)
            tdp_pkg::CND_NEVER:    cond_hit = 1'b0;
            tdp_pkg::CND_ALWAYS:   cond_hit = 1'b1;
            tdp_pkg::CND_NO_START: cond_hit = !start;
            tdp_pkg::CND_LT2:      cond_hit = status.lt2;
            tdp_pkg::CND_LT4:      cond_hit = status.lt4;
            tdp_pkg::CND_EVEN:     cond_hit = status.even;
            tdp_pkg::CND_DIV_BUSY: cond_hit = status.div_busy;
            tdp_pkg::CND_D_GT_Q:   cond_hit = status.d_gt_q;
            default:               cond_hit = 1'b0;
        endcase
        take      = cond_hit || (uw.rem_test && status.rem_zero);
        step_next = take ? uw.target : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tdp_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign op   = uw.op;
    assign busy = (step_reg != tdp_pkg::S_IDLE);

endmodule

>>> rtl/core/tdp_datapath.sv
// Datapath: candidate and divisor registers, bit-serial restoring divider, result register.
module tdp_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [31:0]                 candidate,
    input  tdp_pkg::op_t                op,
    output tdp_pkg::dp_status_t         status,
    output logic                        done,
    output logic                        prime_flag
);

    localparam int W = tdp_pkg::NUM_WIDTH;

    logic [W-1:0]              n_reg,   n_next;
    logic [W-1:0]              d_reg,   d_next;
    logic [W-1:0]              rem_reg, rem_next;
    logic [W-1:0]              qn_reg,  qn_next;    // dividend shifts out, quotient shifts in
    logic [tdp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic                      flag_reg, flag_next;

    logic [W:0]                rem_sh;
    logic [W:0]                rem_sub;
    logic                      fits;

    assign rem_sh  = {rem_reg, qn_reg[W-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    assign fits    = !rem_sub[W];

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        qn_next   = qn_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        flag_next = flag_reg;
        unique case (op)
            tdp_pkg::OP_NOP: ;
            tdp_pkg::OP_LOAD:
            begin
                n_next = W'(candidate);
                d_next = W'(3);
            end
            tdp_pkg::OP_DIV_INIT:
            begin
                rem_next = '0;
                qn_next  = n_reg;
                cnt_next = '0;
            end
            tdp_pkg::OP_DIV_STEP:
            begin
                rem_next = fits ? rem_sub[W-1:0] : rem_sh[W-1:0];
                qn_next  = {qn_reg[W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
            end
            tdp_pkg::OP_D_INC:
            begin
                d_next = d_reg + W'(2);
            end
            tdp_pkg::OP_EMIT0:
            begin
                done_next = 1'b1;
                flag_next = 1'b0;
            end
            tdp_pkg::OP_EMIT1:
            begin
                done_next = 1'b1;
                flag_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            flag_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        qn_reg  <= qn_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        status.lt2      = (n_reg < W'(2));
        status.lt4      = (n_reg < W'(4));
        status.even     = !n_reg[0];
        status.div_busy = (cnt_reg != tdp_pkg::CNT_W'(W - 1));
        status.d_gt_q   = (d_reg > qn_reg);     // d > n/d  <=>  d*d > n
        status.rem_zero = (rem_reg == '0);
    end

    assign done       = done_reg;
    assign prime_flag = flag_reg;

endmodule

>>> rtl/core/trial_division_prime_test.sv
// Top level of the trial-division primality tester.
//
// Usage: drive candidate and raise start while busy is low; that edge accepts
// the transaction. busy stays high until the answer is produced. The result
// appears on prime_flag, marked by done for exactly one cycle; the receiver
// cannot stall it, and the next transaction may be started in that cycle.
// Values below 2 and even values above 2 report 0; 2 and 3 report 1.
// Odd values from 5 up try the odd divisors from 3 upward in turn, ending
// when the last divisor's square exceeds the candidate (result 1) or when
// it divides the candidate (result 0). Each trial runs the one-bit-per-cycle
// restoring divider over all 32 bits of the candidate plus 4 microcode steps
// of setup, quotient compare, remainder test and divisor increment. For
// 32-bit primes near the top of the range this is about 32768 trials.
// Reset returns the sequencer to its idle step; no transaction is pending.
module trial_division_prime_test (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] candidate,
    output logic        done,
    output logic        prime_flag
);

    tdp_pkg::op_t        op;
    tdp_pkg::dp_status_t status;

    tdp_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    tdp_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .candidate  (candidate),
        .op         (op),
        .status     (status),
        .done       (done),
        .prime_flag (prime_flag)
    );

endmodule

>>> sim/trial_division_prime_test_tb.sv
// Self-checking testbench for the trial-division prime tester: directed table, then random.
module trial_division_prime_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] cand;
        bit          typed;
        bit          flag;
    } probe_row_t;

    typedef struct {
        logic [31:0] cand;
        bit          flag;
    } verdict_t;

    localparam int N_PROBES = 20;
    localparam int N_RANDOM = 80;
    localparam int SETTLE_CYCLES = 10;

    // Boundary values get a typed answer; the rest go through the predictor.
    probe_row_t probes [N_PROBES] = '{
        '{32'd0,          1'b1, 1'b0},
        '{32'd1,          1'b1, 1'b0},
        '{32'd2,          1'b1, 1'b1},
        '{32'd3,          1'b1, 1'b1},
        '{32'd4,          1'b1, 1'b0},
        '{32'hFFFF_FFFE,  1'b1, 1'b0},
        '{32'h8000_0000,  1'b1, 1'b0},
        '{32'hFFFF_FFFF,  1'b0, 1'b0},
        '{32'd5,          1'b0, 1'b0},
        '{32'd7,          1'b0, 1'b0},
        '{32'd9,          1'b0, 1'b0},
        '{32'd25,         1'b0, 1'b0},
        '{32'd49,         1'b0, 1'b0},
        '{32'h8000_0001,  1'b0, 1'b0},
        '{32'h5555_5555,  1'b0, 1'b0},
        '{32'd97,         1'b0, 1'b0},
        '{32'd65537,      1'b0, 1'b0},
        '{32'd1000003,    1'b0, 1'b0},
        '{32'd16777213,   1'b0, 1'b0},
        '{32'd16777207,   1'b0, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] candidate;
    logic        done;
    logic        prime_flag;

    verdict_t pending_verdicts [$];
    int       faults;
    int       verdicts_checked;
    int       primes_reported;

    trial_division_prime_test u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .candidate  (candidate),
        .done       (done),
        .prime_flag (prime_flag)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit is_prime_by_trial(input logic [31:0] value);
        longint unsigned n;
        longint unsigned d;
        n = value;
        if (n < 2)
            return 1'b0;
        if (n < 4)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (d = 3; d <= n / d; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // Random candidates: mostly small, some mid-range, and full-width values
    // that are even or carry a small odd factor so each trial loop stays short.
    function automatic logic [31:0] pick_candidate();
        int unsigned small_odd [10] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
        int unsigned r;
        int unsigned p;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 4095);
        if (r < 70)
            return $urandom_range(4096, 1 << 20);
        if (r < 85)
        begin
            p = small_odd[$urandom_range(0, 9)];
            return p * $urandom_range(1, 32'hFFFF_FFFF / p);
        end
        return $urandom & 32'hFFFF_FFFE;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue(input logic [31:0] value, input bit typed, input bit flag);
        verdict_t v;
        start     <= 1'b1;
        candidate <= value;
        do
            @(posedge clk);
        while (busy);
        v.cand = value;
        v.flag = typed ? flag : is_prime_by_trial(value);
        pending_verdicts.push_back(v);
        @(negedge clk);
    endtask

    task automatic idle_for(input int gap);
        if (gap > 0)
        begin
            start     <= 1'b0;
            candidate <= $urandom;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("[%0t] unexpected result prime_flag=%b", $realtime, prime_flag);
            end
            else
            begin
                v = pending_verdicts.pop_front();
                verdicts_checked++;
                if (prime_flag === 1'b1)
                    primes_reported++;
                if (prime_flag !== v.flag)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("[%0t] candidate %0d: expected prime_flag=%b, got %b",
                                 $realtime, v.cand, v.flag, prime_flag);
                end
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("Timeout waiting for results, %0d still outstanding",
                 pending_verdicts.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int burst_left;
        faults           = 0;
        verdicts_checked = 0;
        primes_reported  = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        candidate = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (probes[i])
        begin
            issue(probes[i].cand, probes[i].typed, probes[i].flag);
            idle_for(pick_gap());
        end
        // hold off until every directed answer is back
        drain();
        @(negedge clk);

        burst_left = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                drain();
                @(negedge clk);
            end
            issue(pick_candidate(), 1'b0, 1'b0);
            if (burst_left == 0 && $urandom_range(0, 7) == 0)
                burst_left = $urandom_range(4, 10);
            if (burst_left > 0)
                burst_left--;
            else
                idle_for(pick_gap());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d table transactions and %0d random transactions", N_PROBES, N_RANDOM);
        $display("Checked %0d results, %0d reported prime, %0d mismatches",
                 verdicts_checked, primes_reported, faults);
        if (faults == 0 && pending_verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
